>>> rtl/core/cosf_pkg.sv
// Package with the types, constants and helper functions of the cascaded one-pole filter.
package cosf_pkg;

	localparam int STAGE_COUNT   = 26;
	localparam int CHANNEL_COUNT = 2;
	localparam int MEM_DEPTH     = STAGE_COUNT * CHANNEL_COUNT;
	localparam int MEM_AW        = $clog2(MEM_DEPTH);
	localparam int STAGE_W       = $clog2(STAGE_COUNT);
	localparam int CH_W          = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

	localparam int SMP_W   = 24;
	localparam int COEFF_W = 24;
	localparam int WORD_W  = 32;
	localparam int OPB_W   = 31;
	localparam int PROD_W  = WORD_W + OPB_W;
	localparam int ACC_W   = 58;
	localparam int GAIN_W  = 29;

	localparam logic [COEFF_W-1:0]       COEFF_RESET  = COEFF_W'(855980);
	localparam logic [GAIN_W-1:0]        GAIN_EXCESS0 = GAIN_W'(450971566);
	localparam logic [STAGE_W-1:0]       STAGE_LAST   = STAGE_W'(STAGE_COUNT - 1);
	localparam logic [CH_W-1:0]          CH_LAST      = CH_W'(CHANNEL_COUNT - 1);
	localparam logic signed [WORD_W-1:0] ONE_Q30      = WORD_W'(32'sd1073741824);
	localparam logic signed [WORD_W-1:0] MONE_Q30     = -ONE_Q30;

	// Register index, taken from paddr[2].
	localparam logic REG_SMOOTHING_COEFF = 1'b0;

	typedef logic signed [SMP_W-1:0]              sample_t;
	typedef logic [CHANNEL_COUNT-1:0][SMP_W-1:0]  frame_t;
	typedef logic signed [WORD_W-1:0]             word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GAIN,
		ST_MEMB,
		ST_COEF,
		ST_WRITE,
		ST_FINISH,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic              we;
		logic [MEM_AW-1:0] addr;
		word_t             wdata;
	} mem_req_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] a;
		logic signed [OPB_W-1:0]  b;
	} mul_op_t;

	// Clamp a Q4.30 value to [-1, 1], giving a Q2.30 word.
	function automatic word_t clamp_unit(input logic signed [WORD_W+1:0] v);
		word_t r;
		if (v > $signed({{2{ONE_Q30[WORD_W-1]}}, ONE_Q30})) begin
			r = ONE_Q30;
		end else if (v < $signed({{2{MONE_Q30[WORD_W-1]}}, MONE_Q30})) begin
			r = MONE_Q30;
		end else begin
			r = v[WORD_W-1:0];
		end
		return r;
	endfunction

endpackage

>>> rtl/core/cosf_mul.sv
// Shared signed multiplier with a registered product.
module cosf_mul
	import cosf_pkg::*;
(
	input  logic                     clk,
	input  mul_op_t                  op,
	output logic signed [PROD_W-1:0] prod_q
);

	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op.a) * PROD_W'(op.b);
	end

endmodule

>>> rtl/core/cosf_mem.sv
// Stage memory of all channels with per-entry valid bits and a registered read port.
module cosf_mem
	import cosf_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  mem_req_t req,
	output word_t    rdata_q
);

	word_t             mem [MEM_DEPTH];
	logic [MEM_DEPTH-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (req.we) begin
			valid_q[req.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata_q <= valid_q[req.addr] ? mem[req.addr] : '0;
	end

endmodule

>>> rtl/core/cosf_seq.sv
// Sequencer and datapath that run every stage of every channel through the shared multiplier.
module cosf_seq
	import cosf_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [COEFF_W-1:0]  coeff,
	input  logic                in_valid,
	output logic                in_ready,
	input  frame_t              in_frame,
	output logic                out_valid,
	input  logic                out_ready,
	output frame_t              out_frame
);

	st_t                     state_q, state_d;
	logic [STAGE_W-1:0]      k_q;
	logic [CH_W-1:0]         ch_q;
	logic [MEM_AW-1:0]       addr_q;
	logic [GAIN_W-1:0]       d_q;
	word_t                   x_q;
	logic [ACC_W-1:0]        acc_q;
	frame_t                  smp_q;
	frame_t                  res_q;
	logic                    out_valid_q;

	mul_op_t                 mop;
	logic signed [PROD_W-1:0] prod_q;
	mem_req_t                mreq;
	word_t                   mrd_q;

	logic [COEFF_W:0]        na;
	logic signed [PROD_W-1:0] g_tmp;
	logic signed [WORD_W:0]  g_rnd;
	logic signed [WORD_W+1:0] xg;
	word_t                   x_gain;
	logic signed [ACC_W-1:0] upd_sum;
	logic signed [ACC_W-1:0] upd_tmp;
	logic signed [WORD_W+1:0] upd_m;
	word_t                   m_new;
	logic [GAIN_W+1:0]       d_sum;
	word_t                   fin_c;
	logic signed [WORD_W:0]  fin_t;
	logic signed [WORD_W-7:0] fin_r;
	sample_t                 fin_s;
	logic                    accept;
	logic                    load_out;

	cosf_mul u_mul (
		.clk    (clk),
		.op     (mop),
		.prod_q (prod_q)
	);

	cosf_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.rdata_q (mrd_q)
	);

	assign na = {1'b1, {COEFF_W{1'b0}}} - {1'b0, coeff};

	always_comb begin
		g_tmp  = prod_q + (PROD_W'(1) <<< 29);
		g_rnd  = g_tmp[PROD_W-1:30];
		xg     = {{2{x_q[WORD_W-1]}}, x_q} + {g_rnd[WORD_W], g_rnd};
		x_gain = (k_q == '0) ? xg[WORD_W-1:0] : clamp_unit(xg);

		upd_sum = $signed(acc_q) + $signed(prod_q[ACC_W-1:0]);
		upd_tmp = upd_sum + (ACC_W'(1) <<< 23);
		upd_m   = upd_tmp[ACC_W-1:24];
		if (upd_m > (WORD_W+2)'(32'sh7fffffff)) begin
			m_new = 32'sh7fffffff;
		end else if (upd_m < -(WORD_W+2)'(34'sh080000000)) begin
			m_new = 32'sh80000000;
		end else begin
			m_new = upd_m[WORD_W-1:0];
		end

		d_sum = {2'b00, d_q} + {1'b0, d_q, 1'b0} + (GAIN_W+2)'(2);

		fin_c = clamp_unit({{2{x_q[WORD_W-1]}}, x_q});
		fin_t = {fin_c[WORD_W-1], fin_c} + (WORD_W+1)'(64);
		fin_r = fin_t[WORD_W:7];
		if (fin_r > (WORD_W-6)'(24'sh7fffff)) begin
			fin_s = 24'sh7fffff;
		end else begin
			fin_s = fin_r[SMP_W-1:0];
		end
	end

	assign accept   = in_valid && in_ready;
	assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		mop.a       = x_q;
		mop.b       = OPB_W'(d_q);
		mreq.we     = 1'b0;
		mreq.addr   = addr_q;
		mreq.wdata  = m_new;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: begin
				state_d = ST_MEMB;
			end
			ST_MEMB: begin
				mop.a   = mrd_q;
				mop.b   = OPB_W'(na);
				state_d = ST_COEF;
			end
			ST_COEF: begin
				mop.b   = OPB_W'(coeff);
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				mreq.we = 1'b1;
				state_d = (k_q == STAGE_LAST) ? ST_FINISH : ST_GAIN;
			end
			ST_FINISH: begin
				state_d = (ch_q == CH_LAST) ? ST_DONE : ST_GAIN;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			ch_q        <= '0;
			addr_q      <= '0;
			d_q         <= GAIN_EXCESS0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				k_q    <= '0;
				ch_q   <= '0;
				addr_q <= '0;
				d_q    <= GAIN_EXCESS0;
			end else if (state_q == ST_WRITE) begin
				addr_q <= addr_q + MEM_AW'(1);
				d_q    <= d_sum[GAIN_W+1:2];
				if (k_q != STAGE_LAST) begin
					k_q <= k_q + STAGE_W'(1);
				end
			end else if (state_q == ST_FINISH && ch_q != CH_LAST) begin
				k_q  <= '0;
				ch_q <= ch_q + CH_W'(1);
				d_q  <= GAIN_EXCESS0;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= in_frame;
			x_q   <= {in_frame[0][SMP_W-1], in_frame[0], 7'b0};
		end
		unique case (state_q)
			ST_MEMB: begin
				x_q <= x_gain;
			end
			ST_COEF: begin
				acc_q <= prod_q[ACC_W-1:0];
			end
			ST_WRITE: begin
				x_q <= m_new;
			end
			ST_FINISH: begin
				res_q[ch_q] <= fin_s;
				if (ch_q != CH_LAST) begin
					x_q <= {smp_q[ch_q + CH_W'(1)][SMP_W-1], smp_q[ch_q + CH_W'(1)], 7'b0};
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_frame <= res_q;
		end
	end

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_GAIN) && (addr_q == '0) && (k_q == '0))
		else $error("accepted transaction did not start at the first stage");

	a_stage_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (k_q <= STAGE_LAST))
		else $error("stage counter out of range");

	a_gain_bound: assert property (@(posedge clk) disable iff (!arst_n)
		d_q <= GAIN_EXCESS0)
		else $error("gain excess grew");

	a_write_addr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (addr_q < MEM_AW'(MEM_DEPTH)))
		else $error("stage memory address beyond depth");

	a_done_channels: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && ch_q == CH_LAST) |-> (addr_q == MEM_AW'(MEM_DEPTH)
			|| MEM_DEPTH == (1 << MEM_AW)))
		else $error("not every stage was updated before the result");

endmodule

>>> rtl/core/cascaded_onepole_subbass_filter_top.sv
// Top level of the cascaded one-pole sub-bass filter with its register port.
// A new transaction is accepted only in the idle state, after the previous result has
// been loaded for m_tvalid. The work runs on the single shared multiplier, which
// takes three products for each of the 52 stage updates (gain, memory, coefficient).
// Reset clears all stage memories to zero through their valid bits and loads the
// smoothing coefficient with 855980; no clearing pass is needed.
module cascaded_onepole_subbass_filter_top
	import cosf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // left_sample [23:0], right_sample [47:24]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata    // left_out [23:0], right_out [47:24]
);

	logic [COEFF_W-1:0] coeff_q;
	frame_t             out_frame;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= COEFF_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SMOOTHING_COEFF) begin
			coeff_q <= pwdata[COEFF_W-1:0];
		end
	end

	assign prdata = (paddr[2] == REG_SMOOTHING_COEFF) ? {8'b0, coeff_q} : '0;

	cosf_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.coeff     (coeff_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_frame  (s_tdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_frame (out_frame)
	);

	assign m_tdata = out_frame;

endmodule
